FILE: sv/ack_packet_deframer_defines.svh
// assertion macros for the ack packet deframer
`ifndef ACK_PACKET_DEFRAMER_DEFINES_SVH
`define ACK_PACKET_DEFRAMER_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define APD_ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define APD_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: sv/apd_pkg.sv
`timescale 1ns / 1ps

package apd_pkg;

   localparam logic [1:0] KIND_ARM  = 2'd0;
   localparam logic [1:0] KIND_BYTE = 2'd1;
   localparam logic [1:0] KIND_TICK = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BADSUM  = 2'd1;
   localparam logic [1:0] ST_TIMEOUT = 2'd2;

   localparam logic RK_PARAM  = 1'b0;
   localparam logic RK_STATUS = 1'b1;

   localparam logic [0:0] CSR_HEADER_WORD = 1'd0;
   localparam logic [0:0] CSR_ACK_TYPE    = 1'd1;

   localparam logic [15:0] HEADER_WORD_RESET = 16'hEF01;
   localparam logic [7:0]  ACK_TYPE_RESET    = 8'h07;

   localparam logic [3:0] HDR_FIRST  = 4'd0;
   localparam logic [3:0] HDR_SECOND = 4'd1;
   localparam logic [3:0] HDR_TYPE   = 4'd6;
   localparam logic [3:0] HDR_LEN_HI = 4'd7;
   localparam logic [3:0] HDR_LEN_LO = 4'd8;
   localparam logic [3:0] HDR_CODE   = 4'd9;

   localparam logic [15:0] TICK_MAX      = 16'hFFFF;
   localparam logic [15:0] LEN_OVERHEAD  = 16'd3;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HUNT,
      PH_PARAM,
      PH_SUMHI,
      PH_SUMLO
   } apd_phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  rx_byte;
      logic [15:0] timeout_ticks;
   } apd_item_type;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  param_byte;
      logic [15:0] param_index;
      logic [1:0]  status;
      logic [7:0]  confirm_code;
   } apd_result_type;

   typedef struct packed {
      logic [15:0] header_word;
      logic [7:0]  ack_type_code;
   } apd_cfg_type;

endpackage

FILE: sv/apd_req_if.sv
`timescale 1ns / 1ps

interface apd_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  rx_byte;
   logic [15:0] timeout_ticks;

   modport source (output valid, kind, rx_byte, timeout_ticks, input ready);
   modport sink (input valid, kind, rx_byte, timeout_ticks, output ready);
endinterface

FILE: sv/apd_rsp_if.sv
`timescale 1ns / 1ps

interface apd_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [7:0]  param_byte;
   logic [15:0] param_index;
   logic [1:0]  status;
   logic [7:0]  confirm_code;

   modport source (output valid, result_kind, param_byte, param_index, status,
                   confirm_code, input ready);
   modport sink (input valid, result_kind, param_byte, param_index, status,
                 confirm_code, output ready);
endinterface

FILE: sv/ack_packet_deframer.sv
`timescale 1ns / 1ps
// channel  | dir | beat contents
// req_ch   | in  | kind, rx_byte, timeout_ticks
// rsp_ch   | out | result_kind, param_byte, param_index, status, confirm_code
// csr_*    | in  | csr_index, csr_wdata on csr_we
//
// one beat per cycle sustained while rsp is ready; a result passes the input register
// and then the result register around the parser before it is on rsp
// synchronous reset returns to idle, config to 0xef01 / 0x07
// a stalled result holds its register while the input register keeps one beat

`include "ack_packet_deframer_defines.svh"

module ack_packet_deframer (
   input  logic        clock,
   input  logic        reset,
   apd_req_if.sink     req_ch,
   apd_rsp_if.source   rsp_ch,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import apd_pkg::*;

   logic           advance;
   logic           item_valid;
   logic           item_fire;
   logic           res_valid;
   apd_item_type   req_item;
   apd_item_type   item;
   apd_result_type res;
   apd_result_type rsp_res;
   apd_cfg_type    cfg_ff, cfg_in;

   assign req_item.kind          = req_ch.kind;
   assign req_item.rx_byte       = req_ch.rx_byte;
   assign req_item.timeout_ticks = req_ch.timeout_ticks;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_HEADER_WORD: cfg_in.header_word   = csr_wdata;
            CSR_ACK_TYPE:    cfg_in.ack_type_code = csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_word   <= HEADER_WORD_RESET;
         cfg_ff.ack_type_code <= ACK_TYPE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   apd_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_ready  (req_ch.ready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   assign item_fire = item_valid && advance;

   apd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .item_fire (item_fire),
      .item      (item),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   apd_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_res   (rsp_res),
      .advance   (advance)
   );

   assign rsp_ch.result_kind  = rsp_res.result_kind;
   assign rsp_ch.param_byte   = rsp_res.param_byte;
   assign rsp_ch.param_index  = rsp_res.param_index;
   assign rsp_ch.status       = rsp_res.status;
   assign rsp_ch.confirm_code = rsp_res.confirm_code;

   `APD_ASSERT_IMPLIES(a_ready_only_when_full, !req_ch.ready,
      item_valid && !advance, "input stalled without a held beat")
   `APD_ASSERT_IMPLIES(a_param_clean, rsp_ch.valid && rsp_ch.result_kind == RK_PARAM,
      rsp_ch.status == ST_OK && rsp_ch.confirm_code == 8'h00, "parameter beat carries status")
   `APD_ASSERT_IMPLIES(a_timeout_clean, rsp_ch.valid && rsp_ch.status == ST_TIMEOUT,
      rsp_ch.result_kind == RK_STATUS && rsp_ch.confirm_code == 8'h00
      && rsp_ch.param_index == 16'h0000, "timeout beat malformed")
   `APD_ASSERT_HOLDS(a_status_range, !rsp_ch.valid || rsp_ch.status == ST_OK
      || rsp_ch.status == ST_BADSUM || rsp_ch.status == ST_TIMEOUT, "undefined status code")

endmodule

FILE: sv/apd_in_stage.sv
`timescale 1ns / 1ps

module apd_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  apd_pkg::apd_item_type req_item,
   input  logic                  advance,
   output logic                  item_valid,
   output apd_pkg::apd_item_type item
);
   import apd_pkg::*;

   logic         valid_ff, valid_in;
   apd_item_type item_ff, item_in;

   assign req_ready  = !valid_ff || advance;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         item_in  = req_item;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end
endmodule

FILE: sv/apd_core.sv
`timescale 1ns / 1ps

module apd_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_fire,
   input  apd_pkg::apd_item_type   item,
   input  apd_pkg::apd_cfg_type    cfg,
   output logic                    res_valid,
   output apd_pkg::apd_result_type res
);
   import apd_pkg::*;

   apd_phase_type phase_ff, phase_in;
   logic [3:0]  hdr_count_ff, hdr_count_in;
   logic [7:0]  first_byte_ff, first_byte_in;
   logic [7:0]  type_seen_ff, type_seen_in;
   logic [15:0] length_ff, length_in;
   logic [7:0]  code_seen_ff, code_seen_in;
   logic [15:0] param_count_ff, param_count_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  sum_high_ff, sum_high_in;
   logic [15:0] tick_count_ff, tick_count_in;
   logic [15:0] tick_limit_ff, tick_limit_in;

   logic [15:0] param_total;
   logic [15:0] count_next;
   logic [15:0] tick_sat;
   logic [7:0]  b;

   always_comb begin
      phase_in       = phase_ff;
      hdr_count_in   = hdr_count_ff;
      first_byte_in  = first_byte_ff;
      type_seen_in   = type_seen_ff;
      length_in      = length_ff;
      code_seen_in   = code_seen_ff;
      param_count_in = param_count_ff;
      sum_in         = sum_ff;
      sum_high_in    = sum_high_ff;
      tick_count_in  = tick_count_ff;
      tick_limit_in  = tick_limit_ff;
      res_valid      = 1'b0;
      res            = '0;
      b              = item.rx_byte;
      param_total    = (length_ff < LEN_OVERHEAD) ? 16'd0 : length_ff - LEN_OVERHEAD;
      count_next     = param_count_ff + 16'd1;
      tick_sat       = (tick_count_ff == TICK_MAX) ? tick_count_ff : tick_count_ff + 16'd1;

      if (item_fire) begin
         case (item.kind)
            KIND_ARM: begin
               phase_in       = PH_HUNT;
               hdr_count_in   = HDR_FIRST;
               first_byte_in  = '0;
               type_seen_in   = '0;
               length_in      = '0;
               code_seen_in   = '0;
               param_count_in = '0;
               sum_in         = '0;
               sum_high_in    = '0;
               tick_count_in  = '0;
               tick_limit_in  = item.timeout_ticks;
            end
            KIND_TICK: begin
               if (phase_ff == PH_HUNT) begin
                  tick_count_in = tick_sat;
                  if (tick_sat >= tick_limit_ff) begin
                     phase_in         = PH_IDLE;
                     hdr_count_in     = HDR_FIRST;
                     res_valid        = 1'b1;
                     res.result_kind  = RK_STATUS;
                     res.status       = ST_TIMEOUT;
                  end
               end
            end
            KIND_BYTE: begin
               case (phase_ff)
                  PH_HUNT: begin
                     case (hdr_count_ff)
                        HDR_FIRST: begin
                           first_byte_in = b;
                           hdr_count_in  = HDR_SECOND;
                        end
                        HDR_SECOND: begin
                           if (first_byte_ff == cfg.header_word[15:8] &&
                               b == cfg.header_word[7:0]) begin
                              hdr_count_in = hdr_count_ff + 4'd1;
                           end else begin
                              hdr_count_in = HDR_FIRST;
                           end
                        end
                        HDR_TYPE: begin
                           type_seen_in = b;
                           hdr_count_in = HDR_LEN_HI;
                        end
                        HDR_LEN_HI: begin
                           length_in    = {b, 8'h00};
                           hdr_count_in = HDR_LEN_LO;
                        end
                        HDR_LEN_LO: begin
                           length_in    = {length_ff[15:8], b};
                           hdr_count_in = HDR_CODE;
                        end
                        HDR_CODE: begin
                           code_seen_in = b;
                           hdr_count_in = HDR_FIRST;
                           if (type_seen_ff == cfg.ack_type_code) begin
                              sum_in = {8'h00, type_seen_ff} + {8'h00, length_ff[15:8]}
                                     + {8'h00, length_ff[7:0]} + {8'h00, b};
                              param_count_in = '0;
                              phase_in = (param_total == 16'd0) ? PH_SUMHI : PH_PARAM;
                           end
                        end
                        default: begin
                           hdr_count_in = (hdr_count_ff < HDR_CODE) ?
                                          hdr_count_ff + 4'd1 : HDR_FIRST;
                        end
                     endcase
                  end
                  PH_PARAM: begin
                     sum_in         = sum_ff + {8'h00, b};
                     param_count_in = count_next;
                     if (count_next >= param_total) begin
                        phase_in = PH_SUMHI;
                     end
                     res_valid       = 1'b1;
                     res.result_kind = RK_PARAM;
                     res.param_byte  = b;
                     res.param_index = param_count_ff;
                  end
                  PH_SUMHI: begin
                     sum_high_in = b;
                     phase_in    = PH_SUMLO;
                  end
                  PH_SUMLO: begin
                     phase_in         = PH_IDLE;
                     res_valid        = 1'b1;
                     res.result_kind  = RK_STATUS;
                     res.status       = (sum_high_ff == sum_ff[15:8] && b == sum_ff[7:0]) ?
                                        ST_OK : ST_BADSUM;
                     res.confirm_code = code_seen_ff;
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         hdr_count_ff   <= HDR_FIRST;
         first_byte_ff  <= '0;
         type_seen_ff   <= '0;
         length_ff      <= '0;
         code_seen_ff   <= '0;
         param_count_ff <= '0;
         sum_ff         <= '0;
         sum_high_ff    <= '0;
         tick_count_ff  <= '0;
         tick_limit_ff  <= '0;
      end else begin
         phase_ff       <= phase_in;
         hdr_count_ff   <= hdr_count_in;
         first_byte_ff  <= first_byte_in;
         type_seen_ff   <= type_seen_in;
         length_ff      <= length_in;
         code_seen_ff   <= code_seen_in;
         param_count_ff <= param_count_in;
         sum_ff         <= sum_in;
         sum_high_ff    <= sum_high_in;
         tick_count_ff  <= tick_count_in;
         tick_limit_ff  <= tick_limit_in;
      end
   end
endmodule

FILE: sv/apd_out_stage.sv
`timescale 1ns / 1ps

module apd_out_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    res_valid,
   input  apd_pkg::apd_result_type res,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output apd_pkg::apd_result_type rsp_res,
   output logic                    advance
);
   import apd_pkg::*;

   logic           valid_ff, valid_in;
   apd_result_type res_ff, res_in;

   assign advance   = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_res   = res_ff;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (advance) begin
         valid_in = res_valid;
         res_in   = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end
endmodule
